// File: src/tac_pkg.sv
`timescale 1ns / 1ps
// Package for the thermistor ADC to Celsius converter.
// Holds the calibration table, widths, shared types and state codes; no dependencies.
package tac_pkg;

   localparam int TableRows   = 64;
   localparam int StepDegrees = 5;
   localparam int AdcBits     = 10;
   localparam int TempBits    = 10;
   localparam int IdxBits     = $clog2(TableRows);
   localparam int DropBits    = $clog2(StepDegrees + 1);
   localparam int NumBits     = AdcBits + DropBits;

   typedef logic [AdcBits-1:0]         adc_type;
   typedef logic signed [TempBits-1:0] temp_type;
   typedef logic [IdxBits-1:0]         idx_type;
   typedef logic [DropBits-1:0]        drop_type;
   typedef logic [NumBits-1:0]         num_type;

   // Calibration points: ADC codes rise, temperatures fall in fixed steps.
   localparam adc_type AdcRom [TableRows] = '{
      10'd23,   10'd25,   10'd27,   10'd28,   10'd31,   10'd33,   10'd35,   10'd38,
      10'd41,   10'd44,   10'd48,   10'd52,   10'd56,   10'd61,   10'd66,   10'd71,
      10'd78,   10'd84,   10'd92,   10'd100,  10'd109,  10'd120,  10'd131,  10'd143,
      10'd156,  10'd171,  10'd187,  10'd205,  10'd224,  10'd245,  10'd268,  10'd293,
      10'd320,  10'd348,  10'd379,  10'd411,  10'd445,  10'd480,  10'd516,  10'd553,
      10'd591,  10'd628,  10'd665,  10'd702,  10'd737,  10'd770,  10'd801,  10'd830,
      10'd857,  10'd881,  10'd903,  10'd922,  10'd939,  10'd954,  10'd966,  10'd977,
      10'd985,  10'd993,  10'd999,  10'd1004, 10'd1008, 10'd1012, 10'd1016, 10'd1020
   };

   localparam temp_type DegRom [TableRows] = '{
      10'sd300, 10'sd295, 10'sd290, 10'sd285, 10'sd280, 10'sd275, 10'sd270, 10'sd265,
      10'sd260, 10'sd255, 10'sd250, 10'sd245, 10'sd240, 10'sd235, 10'sd230, 10'sd225,
      10'sd220, 10'sd215, 10'sd210, 10'sd205, 10'sd200, 10'sd195, 10'sd190, 10'sd185,
      10'sd180, 10'sd175, 10'sd170, 10'sd165, 10'sd160, 10'sd155, 10'sd150, 10'sd145,
      10'sd140, 10'sd135, 10'sd130, 10'sd125, 10'sd120, 10'sd115, 10'sd110, 10'sd105,
      10'sd100, 10'sd95,  10'sd90,  10'sd85,  10'sd80,  10'sd75,  10'sd70,  10'sd65,
      10'sd60,  10'sd55,  10'sd50,  10'sd45,  10'sd40,  10'sd35,  10'sd30,  10'sd25,
      10'sd20,  10'sd15,  10'sd10,  10'sd5,   10'sd0,   -10'sd5,  -10'sd10, -10'sd15
   };

   // Outcome of the table walk, handed from the search unit to the sequencer.
   typedef struct packed {
      logic     valid;
      logic     flag;
      logic     exact;
      temp_type base;
      adc_type  offset;
      adc_type  span;
   } hit_type;

   typedef enum logic [3:0] {
      StIdle   = 4'b0001,
      StSearch = 4'b0010,
      StDivide = 4'b0100,
      StResp   = 4'b1000
   } state_type;

endpackage

// File: src/tac_intf.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the thermistor converter.
// Depends on tac_pkg for the payload types.
interface tac_req_if;
   logic             valid;
   logic             ready;
   tac_pkg::adc_type adc_value;

   modport source (output valid, output adc_value, input ready);
   modport sink (input valid, input adc_value, output ready);
endinterface

interface tac_rsp_if;
   logic              valid;
   logic              ready;
   tac_pkg::temp_type temp_celsius;
   logic              out_of_range;

   modport source (output valid, output temp_celsius, output out_of_range, input ready);
   modport sink (input valid, input temp_celsius, input out_of_range, output ready);
endinterface

// File: src/tac_search.sv
`timescale 1ns / 1ps
// Table walk: compares the reading against one calibration row per cycle.
// Depends on tac_pkg for the table and the hit_type result struct.
module tac_search (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  tac_pkg::adc_type adc_value,
   output tac_pkg::hit_type hit
);
   import tac_pkg::*;

   logic     busy_ff, busy_in;
   idx_type  idx_ff, idx_in;
   adc_type  reading_ff, reading_in;
   adc_type  prev_adc_ff, prev_adc_in;
   temp_type prev_deg_ff, prev_deg_in;
   hit_type  hit_ff, hit_in;

   adc_type           cur_adc;
   temp_type          cur_deg;
   logic [AdcBits:0]  diff;
   logic              lt;
   logic              eq;

   assign cur_adc = AdcRom[idx_ff];
   assign cur_deg = DegRom[idx_ff];
   // One subtractor gives both the equal and the less-than answer.
   assign diff    = {1'b0, reading_ff} - {1'b0, cur_adc};
   assign lt      = diff[AdcBits];
   assign eq      = (diff == '0);

   always_comb begin
      busy_in     = busy_ff;
      idx_in      = idx_ff;
      reading_in  = reading_ff;
      prev_adc_in = prev_adc_ff;
      prev_deg_in = prev_deg_ff;
      hit_in      = hit_ff;
      hit_in.valid = 1'b0;
      if (start) begin
         busy_in    = 1'b1;
         idx_in     = '0;
         reading_in = adc_value;
      end else if (busy_ff) begin
         priority if (eq) begin
            busy_in      = 1'b0;
            hit_in.valid = 1'b1;
            hit_in.flag  = 1'b0;
            hit_in.exact = 1'b1;
            hit_in.base  = cur_deg;
         end else if (lt) begin
            busy_in      = 1'b0;
            hit_in.valid = 1'b1;
            if (idx_ff == '0) begin
               // Below the first row: saturate to the hot end.
               hit_in.flag  = 1'b1;
               hit_in.exact = 1'b1;
               hit_in.base  = cur_deg;
            end else begin
               hit_in.flag   = 1'b0;
               hit_in.exact  = 1'b0;
               hit_in.base   = prev_deg_ff;
               hit_in.offset = reading_ff - prev_adc_ff;
               hit_in.span   = cur_adc - prev_adc_ff;
            end
         end else if (idx_ff == idx_type'(TableRows - 1)) begin
            // Above the last row: saturate to the cold end.
            busy_in      = 1'b0;
            hit_in.valid = 1'b1;
            hit_in.flag  = 1'b1;
            hit_in.exact = 1'b1;
            hit_in.base  = cur_deg;
         end else begin
            idx_in      = idx_ff + idx_type'(1);
            prev_adc_in = cur_adc;
            prev_deg_in = cur_deg;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         hit_ff.valid <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         hit_ff.valid <= hit_in.valid;
      end
      idx_ff        <= idx_in;
      reading_ff    <= reading_in;
      prev_adc_ff   <= prev_adc_in;
      prev_deg_ff   <= prev_deg_in;
      hit_ff.flag   <= hit_in.flag;
      hit_ff.exact  <= hit_in.exact;
      hit_ff.base   <= hit_in.base;
      hit_ff.offset <= hit_in.offset;
      hit_ff.span   <= hit_in.span;
   end

   assign hit = hit_ff;

endmodule

// File: src/tac_divider.sv
`timescale 1ns / 1ps
// Ceiling divider for the interpolation drop, by repeated subtraction.
// Depends on tac_pkg for widths.
module tac_divider (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  tac_pkg::adc_type  offset,
   input  tac_pkg::adc_type  span,
   output logic              done,
   output tac_pkg::drop_type drop
);
   import tac_pkg::*;

   logic     busy_ff, busy_in;
   logic     done_ff, done_in;
   num_type  rem_ff, rem_in;
   num_type  span_ff, span_in;
   drop_type quo_ff, quo_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      span_in = span_ff;
      quo_in  = quo_ff;
      if (load) begin
         // Adding span minus one turns the floor quotient into a ceiling.
         busy_in = 1'b1;
         rem_in  = num_type'(StepDegrees) * num_type'(offset) + num_type'(span)
                   - num_type'(1);
         span_in = num_type'(span);
         quo_in  = '0;
      end else if (busy_ff) begin
         if (rem_ff >= span_ff) begin
            rem_in = rem_ff - span_ff;
            quo_in = quo_ff + drop_type'(1);
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      span_ff <= span_in;
      quo_ff  <= quo_in;
   end

   assign done = done_ff;
   assign drop = quo_ff;

endmodule

// File: src/thermistor_adc_to_celsius_core.sv
`timescale 1ns / 1ps
// Top level of the thermistor ADC to Celsius converter.
// Depends on tac_pkg, tac_intf, tac_search and tac_divider.

// Converts one 10-bit thermistor reading per request into whole degrees
// Celsius by walking a 64-row calibration table and interpolating linearly
// between the two rows that bracket the reading, rounding the drop up.
// Readings outside the table saturate to 300 or -15 and set out_of_range.
// One request is handled at a time; req ready is high only while idle.
// The table walk visits one row per cycle, and an interpolated reading then
// passes through the repeated-subtraction divider before its response.
module thermistor_adc_to_celsius_core (
   input logic      clock,
   input logic      reset,
   tac_req_if.sink   req_ch,
   tac_rsp_if.source rsp_ch
);
   import tac_pkg::*;

   state_type state_ff, state_in;
   temp_type  base_ff, base_in;
   temp_type  temp_ff, temp_in;
   logic      flag_ff, flag_in;

   hit_type  hit;
   logic     div_done;
   drop_type drop;
   logic     req_take;
   logic     div_load;

   assign req_take = req_ch.valid && req_ch.ready;
   assign div_load = (state_ff == StSearch) && hit.valid && !hit.exact;

   tac_search u_search (
      .clock     (clock),
      .reset     (reset),
      .start     (req_take),
      .adc_value (req_ch.adc_value),
      .hit       (hit)
   );

   tac_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .load   (div_load),
      .offset (hit.offset),
      .span   (hit.span),
      .done   (div_done),
      .drop   (drop)
   );

   always_comb begin
      state_in = state_ff;
      base_in  = base_ff;
      temp_in  = temp_ff;
      flag_in  = flag_ff;
      unique case (state_ff)
         StIdle: begin
            if (req_take) begin
               state_in = StSearch;
            end
         end
         StSearch: begin
            if (hit.valid) begin
               flag_in = hit.flag;
               base_in = hit.base;
               if (hit.exact) begin
                  temp_in  = hit.base;
                  state_in = StResp;
               end else begin
                  state_in = StDivide;
               end
            end
         end
         StDivide: begin
            if (div_done) begin
               temp_in  = base_ff - temp_type'(drop);
               state_in = StResp;
            end
         end
         StResp: begin
            if (rsp_ch.ready) begin
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
      base_ff <= base_in;
      temp_ff <= temp_in;
      flag_ff <= flag_in;
   end

   assign req_ch.ready        = (state_ff == StIdle);
   assign rsp_ch.valid        = (state_ff == StResp);
   assign rsp_ch.temp_celsius = temp_ff;
   assign rsp_ch.out_of_range = flag_ff;

`ifndef NO_ASSERTIONS
   a_start_search: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == StSearch))
      else $error("accepted request did not start the table walk");

   a_hit_in_search: assert property (@(posedge clock) disable iff (reset)
      hit.valid |-> (state_ff == StSearch))
      else $error("table walk finished outside the search state");

   a_div_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == StDivide))
      else $error("divider finished outside the divide state");

   a_saturated: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.out_of_range) |->
         (rsp_ch.temp_celsius == DegRom[0]) ||
         (rsp_ch.temp_celsius == DegRom[TableRows-1]))
      else $error("out-of-range response not saturated to a table end");
`endif

endmodule

// File: sim/tb_thermistor_adc_to_celsius_core.sv
`timescale 1ns / 1ps
// Testbench for thermistor_adc_to_celsius_core: directed readings, then random ones.
// Checks each response against its typed row or an interpolator; uses tac_pkg and tac_intf.
module tb_thermistor_adc_to_celsius_core;
   import tac_pkg::*;

   typedef struct packed {
      temp_type temp_celsius;
      logic     out_of_range;
   } celsius_type;

   typedef struct packed {
      adc_type  adc_value;
      logic     typed;
      temp_type temp_celsius;
      logic     out_of_range;
   } directed_row_type;

   localparam int DirectedCount = 23;
   localparam int RandomCount   = 1800;
   localparam int MaxIdle       = 13;
   localparam int DrainCycles   = 80;
   localparam int DrainLimit    = 4000;

   // Rows marked typed carry their expected response; the rest go to the predictor.
   localparam directed_row_type DirectedRows [DirectedCount] = '{
      '{10'd0,    1'b1, 10'sd300,  1'b1},
      '{10'd22,   1'b1, 10'sd300,  1'b1},
      '{10'd23,   1'b1, 10'sd300,  1'b0},
      '{10'd24,   1'b0, 10'sd0,    1'b0},
      '{10'd27,   1'b0, 10'sd0,    1'b0},
      '{10'd28,   1'b0, 10'sd0,    1'b0},
      '{10'd29,   1'b0, 10'sd0,    1'b0},
      '{10'd30,   1'b0, 10'sd0,    1'b0},
      '{10'd591,  1'b1, 10'sd100,  1'b0},
      '{10'd592,  1'b0, 10'sd0,    1'b0},
      '{10'd1008, 1'b1, 10'sd0,    1'b0},
      '{10'd1009, 1'b0, 10'sd0,    1'b0},
      '{10'd1012, 1'b1, -10'sd5,   1'b0},
      '{10'd1019, 1'b0, 10'sd0,    1'b0},
      '{10'd1020, 1'b1, -10'sd15,  1'b0},
      '{10'd1021, 1'b1, -10'sd15,  1'b1},
      '{10'd1023, 1'b1, -10'sd15,  1'b1},
      '{10'd341,  1'b0, 10'sd0,    1'b0},
      '{10'd682,  1'b0, 10'sd0,    1'b0},
      '{10'd512,  1'b0, 10'sd0,    1'b0},
      '{10'd1022, 1'b1, -10'sd15,  1'b1},
      '{10'd511,  1'b0, 10'sd0,    1'b0},
      '{10'd256,  1'b0, 10'sd0,    1'b0}
   };

   logic clock;
   logic reset;

   tac_req_if req_bus ();
   tac_rsp_if rsp_bus ();

   celsius_type pending_temps [$];
   int          mismatch_count = 0;
   int          req_quiet_left = 0;
   int          rsp_quiet_left = 0;

   thermistor_adc_to_celsius_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Interpolates between the two calibration rows around the reading, rounding the drop up.
   function automatic celsius_type convert_reading(adc_type reading);
      celsius_type result;
      int          r;
      int          span;
      int          num;
      r = int'(reading);
      result.out_of_range = 1'b0;
      result.temp_celsius = DegRom[TableRows-1];
      if (r < int'(AdcRom[0])) begin
         result.out_of_range = 1'b1;
         result.temp_celsius = DegRom[0];
         return result;
      end
      if (r > int'(AdcRom[TableRows-1])) begin
         result.out_of_range = 1'b1;
         return result;
      end
      for (int k = 0; k < TableRows; k++) begin
         if (r == int'(AdcRom[k])) begin
            result.temp_celsius = DegRom[k];
            return result;
         end
         if (k > 0 && r < int'(AdcRom[k]) && r > int'(AdcRom[k-1])) begin
            span = int'(AdcRom[k]) - int'(AdcRom[k-1]);
            num  = StepDegrees * (r - int'(AdcRom[k-1]));
            result.temp_celsius = temp_type'(int'(DegRom[k-1]) - (num + span - 1) / span);
            return result;
         end
      end
      result.out_of_range = 1'b1;
      return result;
   endfunction

   // Draws an idle count, with occasional runs of back-to-back traffic.
   function automatic int draw_idle(ref int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         quiet_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, MaxIdle);
   endfunction

   task automatic send_reading(adc_type reading, celsius_type expected);
      int gap;
      gap = draw_idle(req_quiet_left);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.adc_value <= reading;
      do @(posedge clock); while (!req_bus.ready);
      pending_temps.push_back(expected);
   endtask

   function automatic adc_type random_reading();
      int sel;
      int k;
      int r;
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
         r = $urandom_range(0, 1023);
      end else if (sel < 85) begin
         k = $urandom_range(0, TableRows - 1);
         r = int'(AdcRom[k]) + $urandom_range(0, 2) - 1;
      end else if (sel < 93) begin
         r = $urandom_range(0, 30);
      end else begin
         r = $urandom_range(995, 1023);
      end
      if (r < 0) r = 0;
      if (r > 1023) r = 1023;
      return adc_type'(r);
   endfunction

   // Response side: stalls at random, then takes one response and checks it.
   initial begin
      int          gap;
      celsius_type want;
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      forever begin
         gap = draw_idle(rsp_quiet_left);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         if (pending_temps.size() == 0) begin
            $error("unexpected response: temp_celsius %0d, out_of_range %0b",
                   rsp_bus.temp_celsius, rsp_bus.out_of_range);
            mismatch_count++;
         end else begin
            want = pending_temps.pop_front();
            if (rsp_bus.temp_celsius !== want.temp_celsius) begin
               $error("temp_celsius: expected %0d, actual %0d",
                      want.temp_celsius, rsp_bus.temp_celsius);
               mismatch_count++;
            end
            if (rsp_bus.out_of_range !== want.out_of_range) begin
               $error("out_of_range: expected %0b, actual %0b",
                      want.out_of_range, rsp_bus.out_of_range);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      directed_row_type row;
      celsius_type      expected;
      adc_type          reading;
      int               drained;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.adc_value <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DirectedCount; i++) begin
         row = DirectedRows[i];
         if (row.typed) begin
            expected.temp_celsius = row.temp_celsius;
            expected.out_of_range = row.out_of_range;
         end else begin
            expected = convert_reading(row.adc_value);
         end
         send_reading(row.adc_value, expected);
      end

      for (int i = 0; i < RandomCount; i++) begin
         reading = random_reading();
         send_reading(reading, convert_reading(reading));
      end
      req_bus.valid <= 1'b0;

      drained = 0;
      while (pending_temps.size() != 0 && drained < DrainLimit) begin
         @(posedge clock);
         drained++;
      end
      if (pending_temps.size() != 0) begin
         $error("%0d requests left without a response", pending_temps.size());
         mismatch_count++;
      end
      repeat (DrainCycles) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("thermistor_adc_to_celsius_core: match");
      end else begin
         $display("thermistor_adc_to_celsius_core: mismatch");
      end
      $finish;
   end

   initial begin
      #1500000;
      $display("thermistor_adc_to_celsius_core: mismatch");
      $finish;
   end

endmodule

// File: filelist.f
src/tac_pkg.sv
src/tac_intf.sv
src/tac_search.sv
src/tac_divider.sv
src/thermistor_adc_to_celsius_core.sv
sim/tb_thermistor_adc_to_celsius_core.sv
